@@ design/center_band_color_statistics_core_defines.svh @@
// ----------------------------------------------------------------------------
// Center band color statistics: assertion macros
// Clocked assertion wrappers used by the core top level.
// ----------------------------------------------------------------------------
`ifndef CENTER_BAND_COLOR_STATISTICS_CORE_DEFINES_SVH
`define CENTER_BAND_COLOR_STATISTICS_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define CBCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define CBCS_ASSERT_NEVER(lbl, expr, msg) \
  `CBCS_ASSERT(lbl, !(expr), msg)

`endif

@@ design/cbcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Center band color statistics: package
// Widths, constants, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package cbcs_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int FRAME_WIDTH_W = 13;
  localparam int PIX_W         = 8;
  localparam int COUNT_W       = 24;
  localparam int SUM_W         = 32;
  localparam int SQ_W          = 40;
  localparam int QUO_W         = 16;
  localparam int VAR_W         = 14;
  localparam int K_W           = 4;
  localparam int NUM_CH        = 3;

  localparam logic [FRAME_WIDTH_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [COUNT_W-1:0]       COUNT_MAX   = '1;
  localparam logic [QUO_W-1:0]         VAR_MAX     = 16'd16383;

  // Last quotient bit index: mean fits 8 bits, mean of squares 16 bits
  localparam logic [K_W-1:0] MEAN_K = 4'd7;
  localparam logic [K_W-1:0] MSQ_K  = 4'd15;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_LOAD,
    ST_STEP,
    ST_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       div_load;
    logic       div_step;
    logic       store;
    logic       publish;
    logic [1:0] sel_ch;
    logic       sel_sq;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  // floor(x / 3) by reciprocal, exact for every 16-bit x
  function automatic logic [15:0] div3(input logic [15:0] x);
    logic [31:0] p;
    p = x * 16'd43691;
    return 16'(p[31:17]);
  endfunction

endpackage
`default_nettype wire

@@ design/cbcs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Center band color statistics: controller
// Streams pixels, then sequences six divisions and publishes the result word.
// ----------------------------------------------------------------------------
module cbcs_ctrl
  import cbcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    frame_end,
  input  wire logic    out_ready,
  input  wire status_t status,
  output logic         in_ready,
  output logic         out_valid,
  output cmd_t         cmd
);

  state_t     state;
  state_t     state_next;
  logic [1:0] ch;
  logic       sq;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (in_valid && frame_end) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (status.div_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        if (sq && ch == CH_BLUE) state_next = ST_FINISH;
        else state_next = ST_LOAD;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.sel_ch = ch;
    cmd.sel_sq = sq;
    unique case (state)
      ST_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOAD:   cmd.div_load = 1'b1;
      ST_STEP:   cmd.div_step = 1'b1;
      ST_STORE:  cmd.store    = 1'b1;
      ST_FINISH: cmd.publish  = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      ch        <= CH_RED;
      sq        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // advance mean -> mean of squares -> next channel
      if (cmd.store) begin
        if (!sq) begin
          sq <= 1'b1;
        end else begin
          sq <= 1'b0;
          ch <= (ch == CH_BLUE) ? CH_RED : ch + 2'd1;
        end
      end
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ design/cbcs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Center band color statistics: datapath
// Column tracking, band accumulators, shared restoring divider, result regs.
// ----------------------------------------------------------------------------
module cbcs_datapath
  import cbcs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     config_write,
  input  wire logic [FRAME_WIDTH_W-1:0] config_data,
  input  wire cmd_t                     cmd,
  input  wire logic [PIX_W-1:0]         blue_value,
  input  wire logic [PIX_W-1:0]         green_value,
  input  wire logic [PIX_W-1:0]         red_value,
  input  wire logic                     frame_end,
  output status_t                       status,
  output logic [PIX_W-1:0]              mean_red,
  output logic [PIX_W-1:0]              mean_green,
  output logic [PIX_W-1:0]              mean_blue,
  output logic [VAR_W-1:0]              variance_red,
  output logic [VAR_W-1:0]              variance_green,
  output logic [VAR_W-1:0]              variance_blue,
  output logic                          band_empty
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // configuration, held as effective width and band bounds
  logic [FRAME_WIDTH_W-1:0] width_src;
  logic [13:0]              width_clamped;
  logic [WW-1:0]            eff_width;
  logic [CW-1:0]            band_lo;
  logic [CW-1:0]            band_hi;

  logic [CW-1:0]    col;
  logic [WW-1:0]    col_inc;
  logic             in_band;
  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0] sums [NUM_CH];
  logic [SQ_W-1:0]  sqsums [NUM_CH];
  logic [PIX_W-1:0] px [NUM_CH];
  logic [15:0]      px_sq [NUM_CH];

  logic [SQ_W-1:0]  rem;
  logic [SQ_W-1:0]  dvs;
  logic [QUO_W-1:0] quo;
  logic [K_W-1:0]   k;
  logic             ge;

  logic [PIX_W-1:0] mean_st [NUM_CH];
  logic [VAR_W-1:0] var_st [NUM_CH];
  logic [15:0]      mean_sq;
  logic [15:0]      var_diff;
  logic [VAR_W-1:0] var_sat;

  logic [PIX_W-1:0] mean_out [NUM_CH];
  logic [VAR_W-1:0] var_out [NUM_CH];
  logic             count_zero;

  always_comb begin
    width_src = rst ? WIDTH_RESET : config_data;
    if (width_src == '0) width_clamped = 14'd1;
    else if ({1'b0, width_src} > 14'(MAX_WIDTH)) width_clamped = 14'(MAX_WIDTH);
    else width_clamped = {1'b0, width_src};
  end

  always_ff @(posedge clk) begin
    if (rst || config_write) begin
      eff_width <= WW'(width_clamped);
      band_lo   <= CW'(div3(16'(width_clamped)));
      band_hi   <= CW'(div3(16'({width_clamped, 1'b0})));
    end
  end

  assign px[0] = red_value;
  assign px[1] = green_value;
  assign px[2] = blue_value;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) px_sq[c] = px[c] * px[c];
  end

  assign col_inc    = WW'(col) + WW'(1);
  assign in_band    = (col >= band_lo) && (col <= band_hi) && (count != COUNT_MAX);
  assign count_zero = (count == '0);

  assign ge              = (rem >= dvs);
  assign status.div_last = (k == '0);

  always_comb begin
    mean_sq  = 16'(mean_st[cmd.sel_ch]) * 16'(mean_st[cmd.sel_ch]);
    var_diff = (quo >= mean_sq) ? quo - mean_sq : '0;
    var_sat  = (var_diff > VAR_MAX) ? VAR_W'(VAR_MAX) : VAR_W'(var_diff);
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.publish) begin
      col   <= '0;
      count <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c]   <= '0;
        sqsums[c] <= '0;
      end
    end else if (cmd.accept) begin
      if (frame_end || col_inc >= eff_width) col <= '0;
      else col <= CW'(col_inc);
      if (in_band) begin
        count <= count + COUNT_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
          sums[c]   <= sums[c] + SUM_W'(px[c]);
          sqsums[c] <= sqsums[c] + SQ_W'(px_sq[c]);
        end
      end
    end
  end

  // divider: one quotient bit per step, divisor shifts right
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo <= '0;
      if (cmd.sel_sq) begin
        rem <= sqsums[cmd.sel_ch];
        dvs <= SQ_W'(count) << MSQ_K;
        k   <= MSQ_K;
      end else begin
        rem <= SQ_W'(sums[cmd.sel_ch]);
        dvs <= SQ_W'(count) << MEAN_K;
        k   <= MEAN_K;
      end
    end else if (cmd.div_step) begin
      if (ge) rem <= rem - dvs;
      quo <= {quo[QUO_W-2:0], ge};
      dvs <= dvs >> 1;
      k   <= k - K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (!cmd.sel_sq) mean_st[cmd.sel_ch] <= quo[PIX_W-1:0];
      else var_st[cmd.sel_ch] <= var_sat;
    end
  end

  // result word; an empty band reads as zeros
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      band_empty <= count_zero;
      for (int c = 0; c < NUM_CH; c++) begin
        mean_out[c] <= count_zero ? '0 : mean_st[c];
        var_out[c]  <= count_zero ? '0 : var_st[c];
      end
    end
  end

  assign mean_red       = mean_out[0];
  assign mean_green     = mean_out[1];
  assign mean_blue      = mean_out[2];
  assign variance_red   = var_out[0];
  assign variance_green = var_out[1];
  assign variance_blue  = var_out[2];

endmodule
`default_nettype wire

@@ design/center_band_color_statistics_core.sv @@
// A pixel without frame_end gives no result word.
// A frame_end pixel gives its result word after six serial divisions on
// one shared divider (8 or 16 quotient bits each).
// Throughput: one pixel per cycle within a frame; pixels stall during the
// divisions, and longer if the previous result word is still held.
// Reset: synchronous; width returns to 640 and all accumulators clear.
`default_nettype none
// ----------------------------------------------------------------------------
// Center band color statistics core
// Mean and variance per color channel over the center third of each row.
// ----------------------------------------------------------------------------
`include "center_band_color_statistics_core_defines.svh"
module center_band_color_statistics_core
  import cbcs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     config_write,
  input  wire logic [FRAME_WIDTH_W-1:0] config_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [PIX_W-1:0]         blue_value,
  input  wire logic [PIX_W-1:0]         green_value,
  input  wire logic [PIX_W-1:0]         red_value,
  input  wire logic                     frame_end,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [PIX_W-1:0]              mean_red,
  output logic [PIX_W-1:0]              mean_green,
  output logic [PIX_W-1:0]              mean_blue,
  output logic [VAR_W-1:0]              variance_red,
  output logic [VAR_W-1:0]              variance_green,
  output logic [VAR_W-1:0]              variance_blue,
  output logic                          band_empty
);

  cmd_t    cmd;
  status_t status;

  cbcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .frame_end (frame_end),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cbcs_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .config_write   (config_write),
    .config_data    (config_data),
    .cmd            (cmd),
    .blue_value     (blue_value),
    .green_value    (green_value),
    .red_value      (red_value),
    .frame_end      (frame_end),
    .status         (status),
    .mean_red       (mean_red),
    .mean_green     (mean_green),
    .mean_blue      (mean_blue),
    .variance_red   (variance_red),
    .variance_green (variance_green),
    .variance_blue  (variance_blue),
    .band_empty     (band_empty)
  );

  `CBCS_ASSERT(a_end_stalls, in_valid && in_ready && frame_end |=> !in_ready, "frame end did not stall input")
  `CBCS_ASSERT(a_rise_in_div, $rose(out_valid) |-> $past(!in_ready), "result published while streaming")
  `CBCS_ASSERT_NEVER(a_empty_zero, out_valid && band_empty && (mean_red != 0 || mean_green != 0 || mean_blue != 0 || variance_red != 0 || variance_green != 0 || variance_blue != 0), "empty band word not zero")

endmodule
`default_nettype wire

@@ tb/center_band_color_statistics_core_test.sv @@
// ----------------------------------------------------------------------------
// Center band color statistics core: testbench
// Walks a directed table of pixels and width writes, then streams random
// frames under three idling mixes on the pixel and result channels. Each
// word is held to the table or a local predictor of band mean and variance.
// ----------------------------------------------------------------------------
module center_band_color_statistics_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbcs_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 120;

  typedef struct packed {
    logic             empty;
    logic [PIX_W-1:0] mean_r, mean_g, mean_b;
    logic [VAR_W-1:0] spread_r, spread_g, spread_b;
  } band_stats_t;

  typedef enum logic {STEP_WIDTH, STEP_PIXEL} step_kind_t;

  typedef enum logic [1:0] {TONE_NOISE, TONE_EXTREME, TONE_NEAR, TONE_FLAT} tone_t;

  typedef struct packed {
    step_kind_t               kind;
    logic [FRAME_WIDTH_W-1:0] width;
    logic [PIX_W-1:0]         red, green, blue;
    logic                     last;
    logic                     typed;
    band_stats_t              want;
  } plan_row_t;

  localparam band_stats_t NO_WANT    = '0;
  localparam band_stats_t EMPTY_BAND = '{1'b1, 8'd0, 8'd0, 8'd0, 14'd0, 14'd0, 14'd0};

  plan_row_t directed_plan [22] = '{
    // reset width 640: column 0 lies outside the band
    '{STEP_PIXEL, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, EMPTY_BAND},
    '{STEP_WIDTH, 13'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
      '{1'b0, 8'd255, 8'd255, 8'd255, 14'd0, 14'd0, 14'd0}},
    // width 0 acts as 1; a 0/255 pair drives the floored variance to the top
    '{STEP_WIDTH, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd0, 8'd128, 8'd255, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd255, 8'd128, 8'd0, 1'b1, 1'b1,
      '{1'b0, 8'd127, 8'd128, 8'd127, 14'd16383, 14'd0, 14'd16383}},
    '{STEP_WIDTH, 13'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'hAA, 8'h55, 8'hF0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'h55, 8'hAA, 8'h0F, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'h01, 8'h80, 8'hFE, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'h7F, 8'h33, 8'hCC, 1'b1, 1'b0, NO_WANT},
    // widths above the maximum clamp to 4096
    '{STEP_WIDTH, 13'd8191, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'h10, 8'h20, 8'h30, 1'b1, 1'b1, EMPTY_BAND},
    '{STEP_WIDTH, 13'd5, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd200, 8'd10, 8'd30, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd17, 8'd99, 8'd250, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd3, 8'd180, 8'd66, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd90, 8'd45, 8'd128, 1'b0, 1'b0, NO_WANT},
    // shrink the width mid-row: column 4 sits beyond it and wraps next pixel
    '{STEP_WIDTH, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd240, 8'd5, 8'd77, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd11, 8'd22, 8'd33, 1'b0, 1'b0, NO_WANT},
    '{STEP_PIXEL, 13'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b0, NO_WANT}
  };

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     config_write = 1'b0;
  logic [FRAME_WIDTH_W-1:0] config_data  = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic [PIX_W-1:0]         blue_value   = '0;
  logic [PIX_W-1:0]         green_value  = '0;
  logic [PIX_W-1:0]         red_value    = '0;
  logic                     frame_end    = 1'b0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic [PIX_W-1:0]         mean_red, mean_green, mean_blue;
  logic [VAR_W-1:0]         variance_red, variance_green, variance_blue;
  logic                     band_empty;

  int unsigned tx_idle_pct = 35;
  int unsigned rx_idle_pct = 49;
  int unsigned pixels_sent = 0;
  int unsigned fault_count = 0;

  band_stats_t pending_stats [$];

  // Predictor state
  logic [FRAME_WIDTH_W-1:0] pred_width = WIDTH_RESET;
  logic [11:0]              pred_col   = '0;
  logic [COUNT_W-1:0]       pred_n     = '0;
  logic [SUM_W-1:0]         pred_sum   [NUM_CH] = '{default: '0};
  logic [SQ_W-1:0]          pred_sqsum [NUM_CH] = '{default: '0};

  center_band_color_statistics_core DUT (
    .clk           (clk),
    .rst           (rst),
    .config_write  (config_write),
    .config_data   (config_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .blue_value    (blue_value),
    .green_value   (green_value),
    .red_value     (red_value),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean_red      (mean_red),
    .mean_green    (mean_green),
    .mean_blue     (mean_blue),
    .variance_red  (variance_red),
    .variance_green(variance_green),
    .variance_blue (variance_blue),
    .band_empty    (band_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned clamped_width(input logic [FRAME_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w;
  endfunction

  // Accumulate one pixel into the band; on frame end produce the statistics
  task automatic fold_pixel(input logic [PIX_W-1:0] red, green, blue, input logic last,
                            output logic produced, output band_stats_t stats);
    int unsigned      w, lo, hi;
    logic [PIX_W-1:0] px [NUM_CH];
    logic [PIX_W-1:0] mean_ch [NUM_CH];
    logic [VAR_W-1:0] spread_ch [NUM_CH];
    longint unsigned  mean, msq, sq, spread;
    w  = clamped_width(pred_width);
    lo = w / 3;
    hi = (2 * w) / 3;
    px[CH_RED]   = red;
    px[CH_GREEN] = green;
    px[CH_BLUE]  = blue;
    if (pred_col >= lo && pred_col <= hi && pred_n != COUNT_MAX) begin
      pred_n = pred_n + 1'b1;
      for (int k = 0; k < NUM_CH; k++) begin
        pred_sum[k]   = pred_sum[k] + SUM_W'(px[k]);
        pred_sqsum[k] = pred_sqsum[k] + SQ_W'(px[k]) * SQ_W'(px[k]);
      end
    end
    if (pred_col + 1 >= w) pred_col = '0;
    else pred_col = pred_col + 1'b1;

    produced = last;
    stats    = '0;
    if (last) begin
      if (pred_n == 0) begin
        stats.empty = 1'b1;
      end else begin
        for (int k = 0; k < NUM_CH; k++) begin
          mean   = pred_sum[k] / pred_n;
          msq    = pred_sqsum[k] / pred_n;
          sq     = mean * mean;
          spread = (msq >= sq) ? msq - sq : 0;
          if (spread > VAR_MAX) spread = VAR_MAX;
          mean_ch[k]   = PIX_W'(mean);
          spread_ch[k] = VAR_W'(spread);
        end
        stats.mean_r   = mean_ch[CH_RED];
        stats.mean_g   = mean_ch[CH_GREEN];
        stats.mean_b   = mean_ch[CH_BLUE];
        stats.spread_r = spread_ch[CH_RED];
        stats.spread_g = spread_ch[CH_GREEN];
        stats.spread_b = spread_ch[CH_BLUE];
      end
      pred_col = '0;
      pred_n   = '0;
      for (int k = 0; k < NUM_CH; k++) begin
        pred_sum[k]   = '0;
        pred_sqsum[k] = '0;
      end
    end
  endtask

  // All tasks below are entered and left at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] red, green, blue, input logic last,
                            input logic typed = 1'b0, input band_stats_t want = '0);
    logic        produced;
    band_stats_t stats;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    red_value   <= red;
    green_value <= green;
    blue_value  <= blue;
    frame_end   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_pixel(red, green, blue, last, produced, stats);
    if (produced) pending_stats = {pending_stats, (typed ? want : stats)};
    pixels_sent++;
    @(negedge clk);
  endtask

  // Hold off the pixel stream until every pending word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_width(input logic [FRAME_WIDTH_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    config_write <= 1'b1;
    config_data  <= value;
    @(negedge clk);
    config_write <= 1'b0;
    pred_width = value;
  endtask

  function automatic logic [FRAME_WIDTH_W-1:0] pick_width();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 76) return FRAME_WIDTH_W'($urandom_range(1, 12));
    if (roll < 90) return FRAME_WIDTH_W'($urandom_range(13, 40));
    if (roll < 95) return FRAME_WIDTH_W'($urandom_range(41, 200));
    return FRAME_WIDTH_W'($urandom_range(201, 8191));
  endfunction

  function automatic logic [PIX_W-1:0] shade(input tone_t tone, input int unsigned base);
    case (tone)
      TONE_NOISE:   return PIX_W'($urandom_range(0, 255));
      TONE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      TONE_NEAR:    return PIX_W'(base + $urandom_range(0, 15));
      default:      return PIX_W'(base);
    endcase
  endfunction

  task automatic send_frame(input int unsigned len, input logic shift_width);
    tone_t       tone;
    int unsigned base, shift_at;
    tone     = tone_t'($urandom_range(0, 3));
    base     = $urandom_range(0, 255);
    shift_at = shift_width ? $urandom_range(1, len) : len + 1;
    for (int unsigned i = 1; i <= len; i++) begin
      // change the width while the row is under way
      if (i == shift_at) write_width(FRAME_WIDTH_W'($urandom_range(0, 12)));
      send_pixel(shade(tone, base), shade(tone, base), shade(tone, base), i == len);
    end
  endtask

  task automatic run_random_frames(input int unsigned goal, input logic with_wide);
    int unsigned start, weff, len;
    start = pixels_sent;
    if (with_wide) begin
      // clamped width: the band opens at column 1365
      write_width(FRAME_WIDTH_W'($urandom_range(MAX_WIDTH_DEF, 8191)));
      send_frame(1366 + $urandom_range(0, 40), 1'b0);
    end
    while (pixels_sent - start < goal) begin
      if ($urandom_range(0, 99) < 40) write_width(pick_width());
      if ($urandom_range(0, 19) == 0) drain();
      weff = clamped_width(pred_width);
      len  = (weff <= 40) ? $urandom_range(1, 3 * weff + 2) : $urandom_range(1, 60);
      send_frame(len, $urandom_range(0, 99) < 8);
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

  function automatic void log_fault(input string what, input band_stats_t want,
                                    input band_stats_t seen);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s: expected empty=%0d mean=%0d/%0d/%0d var=%0d/%0d/%0d, actual empty=%0d mean=%0d/%0d/%0d var=%0d/%0d/%0d",
               $realtime, what, want.empty, want.mean_r, want.mean_g, want.mean_b,
               want.spread_r, want.spread_g, want.spread_b, seen.empty, seen.mean_r,
               seen.mean_g, seen.mean_b, seen.spread_r, seen.spread_g, seen.spread_b);
  endfunction

  always @(posedge clk) begin
    band_stats_t seen;
    band_stats_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{band_empty, mean_red, mean_green, mean_blue,
               variance_red, variance_green, variance_blue};
      if (pending_stats.size() == 0) begin
        log_fault("word with nothing pending", '0, seen);
      end else begin
        want = pending_stats.pop_front();
        if (seen !== want) log_fault("word mismatch", want, seen);
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_WIDTH) begin
        write_width(directed_plan[i].width);
      end else begin
        send_pixel(directed_plan[i].red, directed_plan[i].green, directed_plan[i].blue,
                   directed_plan[i].last, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    run_random_frames(200, 1'b0);
    drain();
    tx_idle_pct = 49;
    rx_idle_pct = 35;
    run_random_frames(1400, 1'b1);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_frames(200, 1'b0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("PASS center_band_color_statistics_core");
    end else begin
      $display("FAIL center_band_color_statistics_core");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL center_band_color_statistics_core");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/cbcs_pkg.sv
design/cbcs_ctrl.sv
design/cbcs_datapath.sv
design/center_band_color_statistics_core.sv
tb/center_band_color_statistics_core_test.sv
